// ----- design/accessory_packet_framer_macros.svh -----
// Assertion helpers shared by the framer modules.
// Each one is clocked on clk_i and quiet while rst_ni is low.
`ifndef ACCESSORY_PACKET_FRAMER_MACROS_SVH
`define ACCESSORY_PACKET_FRAMER_MACROS_SVH

// Plain property, checked every cycle out of reset.
`define AFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define AFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/afp_pkg.sv -----
package afp_pkg;

  localparam logic [7:0]  SofReset       = 8'h55;
  localparam logic [7:0]  ExtLingoReset  = 8'd4;
  localparam logic [15:0] ShortLenMax    = 16'h00FC;
  localparam int          MaxPayloadDflt = 1024;
  localparam int          QueueDepth     = 2;

  typedef enum logic {
    CfgSofValue      = 1'b0,
    CfgExtendedLingo = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        start_req;
    logic [7:0]  lingo;
    logic [15:0] command;
    logic [15:0] xact_id;
    logic        xact_id_present;
    logic [10:0] payload_length;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       last;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        is_start;
    logic        ext;
    logic        long_len;
    logic        has_tid;
    logic        close;
    logic [7:0]  lingo;
    logic [15:0] command;
    logic [15:0] xact_id;
    logic [15:0] len;
    logic [7:0]  data;
  } cmd_t;

endpackage

// ----- design/afp_queue.sv -----
`include "accessory_packet_framer_macros.svh"

module afp_queue #(
  parameter int Depth = afp_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  afp_pkg::cmd_t push_item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output afp_pkg::cmd_t head_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  afp_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  `AFP_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "push into full queue")
  `AFP_ASSERT_IMPL(a_no_pop_empty, pop_i, head_valid_o, "pop from empty queue")

endmodule

// ----- design/afp_front.sv -----
module afp_front #(
  parameter int MaxPayload = afp_pkg::MaxPayloadDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  afp_pkg::in_item_t in_item_i,
  input  logic [7:0]        ext_lingo_i,
  input  logic              q_full_i,
  output logic              push_o,
  output afp_pkg::cmd_t     push_item_o
);

  logic        open_q, open_d;
  logic [10:0] remaining_q, remaining_d;
  logic        accept;
  logic [10:0] plen_sat;
  logic [10:0] rem_after;
  logic        ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    plen_sat = ({6'b0, in_item_i.payload_length} > 17'(MaxPayload))
             ? 11'(MaxPayload) : in_item_i.payload_length;
    ext       = (in_item_i.lingo == ext_lingo_i);
    rem_after = (remaining_q != '0) ? remaining_q - 11'd1 : '0;

    push_item_o.is_start = in_item_i.start_req;
    push_item_o.ext      = ext;
    push_item_o.has_tid  = in_item_i.xact_id_present;
    push_item_o.lingo    = in_item_i.lingo;
    push_item_o.command  = in_item_i.command;
    push_item_o.xact_id  = in_item_i.xact_id;
    push_item_o.data     = in_item_i.data;
    push_item_o.len      = 16'd1 + (ext ? 16'd2 : 16'd1)
                         + (in_item_i.xact_id_present ? 16'd2 : 16'd0)
                         + 16'(plen_sat);
    push_item_o.long_len = (push_item_o.len > afp_pkg::ShortLenMax);
    push_item_o.close    = in_item_i.start_req ? (plen_sat == '0) : (rem_after == '0);

    // Drop payload bytes that arrive with no open packet.
    push_o = accept && (in_item_i.start_req || open_q);

    open_d      = open_q;
    remaining_d = remaining_q;
    if (push_o) begin
      if (push_item_o.close) begin
        open_d      = 1'b0;
        remaining_d = '0;
      end else begin
        open_d      = 1'b1;
        remaining_d = in_item_i.start_req ? plen_sat : rem_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      remaining_q <= '0;
    end else begin
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

// ----- design/afp_back.sv -----
`include "accessory_packet_framer_macros.svh"

module afp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  afp_pkg::cmd_t      head_item_i,
  output logic               pop_o,
  input  logic [7:0]         sof_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afp_pkg::out_item_t out_item_o
);

  typedef enum logic [3:0] {
    StFirst, StSof, StLen0, StLenHi, StLenLo, StLingo,
    StCmdHi, StCmdLo, StTidHi, StTidLo, StData, StCsum
  } step_e;

  step_e              step_q, cur, nxt;
  logic [7:0]         sum_q, sum_d;
  logic               out_valid_q;
  afp_pkg::out_item_t out_q;
  logic [7:0]         byte_c;
  logic               done;
  logic               advance;

  assign advance     = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = advance && done;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    cur    = (step_q == StFirst) ? (head_item_i.is_start ? StSof : StData) : step_q;
    byte_c = '0;
    nxt    = StFirst;
    done   = 1'b0;
    case (cur)
      StSof: begin
        byte_c = sof_value_i;
        nxt    = head_item_i.long_len ? StLen0 : StLenLo;
      end
      StLen0: begin
        byte_c = 8'h00;
        nxt    = StLenHi;
      end
      StLenHi: begin
        byte_c = head_item_i.len[15:8];
        nxt    = StLenLo;
      end
      StLenLo: begin
        byte_c = head_item_i.len[7:0];
        nxt    = StLingo;
      end
      StLingo: begin
        byte_c = head_item_i.lingo;
        nxt    = head_item_i.ext ? StCmdHi : StCmdLo;
      end
      StCmdHi: begin
        byte_c = head_item_i.command[15:8];
        nxt    = StCmdLo;
      end
      StCmdLo: begin
        byte_c = head_item_i.command[7:0];
        if (head_item_i.has_tid) begin
          nxt = StTidHi;
        end else if (head_item_i.close) begin
          nxt = StCsum;
        end else begin
          done = 1'b1;
        end
      end
      StTidHi: begin
        byte_c = head_item_i.xact_id[15:8];
        nxt    = StTidLo;
      end
      StTidLo, StData: begin
        byte_c = (cur == StData) ? head_item_i.data : head_item_i.xact_id[7:0];
        if (head_item_i.close) begin
          nxt = StCsum;
        end else begin
          done = 1'b1;
        end
      end
      StCsum: begin
        byte_c = 8'd0 - sum_q;
        done   = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    // Restart the sum on SOF; the checksum covers everything after it.
    case (cur)
      StSof:   sum_d = '0;
      StCsum:  sum_d = '0;
      default: sum_d = sum_q + byte_c;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StFirst;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      step_q                <= done ? StFirst : nxt;
      sum_q                 <= sum_d;
      out_valid_q           <= 1'b1;
      out_q.out_byte        <= byte_c;
      out_q.end_of_packet   <= (cur == StCsum);
      out_q.last            <= done;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  `AFP_ASSERT_IMPL(a_mid_item_has_head, step_q != StFirst, head_valid_i,
                   "sequencer mid-item with empty queue")
  `AFP_ASSERT_IMPL(a_eop_is_last, out_valid_o && out_item_o.end_of_packet,
                   out_item_o.last, "checksum byte not marked last")
  `AFP_ASSERT_NEXT(a_pop_loads_last, pop_o, out_valid_o && out_item_o.last,
                   "popped request did not end with a last byte")

endmodule

// ----- design/accessory_packet_framer.sv -----
// An accepted request enters the queue, then its first byte the output register.
// Throughput: one byte per cycle while a request is queued and output is not stalled;
// start: SOF, len, lingo, command, ID if set; payload: data byte; checksum if closing.
// Input takes one request per cycle while the two-entry queue has room.
// Reset (async, active low): no open packet, queue and output empty,
// sof_value = 0x55, extended_lingo = 4.
module accessory_packet_framer #(
  parameter int MaxPayload = afp_pkg::MaxPayloadDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afp_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic [7:0]    sof_value_q;
  logic [7:0]    ext_lingo_q;
  logic          q_full;
  logic          push;
  afp_pkg::cmd_t push_item;
  logic          pop;
  logic          head_valid;
  afp_pkg::cmd_t head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_value_q <= afp_pkg::SofReset;
      ext_lingo_q <= afp_pkg::ExtLingoReset;
    end else if (cfg_we_i) begin
      case (afp_pkg::cfg_idx_e'(cfg_idx_i))
        afp_pkg::CfgSofValue:      sof_value_q <= cfg_wdata_i;
        afp_pkg::CfgExtendedLingo: ext_lingo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  afp_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .ext_lingo_i (ext_lingo_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  afp_queue #(
    .Depth(afp_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  afp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .sof_value_i  (sof_value_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
